// File: hw/rtl/round_robin_thread_scheduler_macros.svh
// Assertion macros for the round-robin thread scheduler checker.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrts check failed");

// Next-cycle implication, disabled during reset.
`define RRTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrts check failed");

`endif

// File: hw/rtl/rrts_pkg.sv
// Types and constants shared by the round-robin thread scheduler.
`timescale 1ns / 1ps
package rrts_pkg;

    localparam int ID_W     = 4;
    localparam int ID_SLOTS = 16;
    localparam int PRIO_W   = 8;
    localparam int TIME_W   = 32;
    localparam int QUANT_W  = 16;
    localparam int PERIOD_W = 24;
    localparam int CFG_W    = 16;

    typedef enum logic [2:0] {
        ST_ABSENT   = 3'd0,
        ST_RUNNABLE = 3'd1,
        ST_RUNNING  = 3'd2,
        ST_BLOCKED  = 3'd3,
        ST_SLEEPING = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ACT_SCHEDULE = 3'd0,
        ACT_ADD      = 3'd1,
        ACT_REMOVE   = 3'd2,
        ACT_RETIRE   = 3'd3,
        ACT_WAIT     = 3'd4
    } t_action;

    typedef enum logic {
        CFG_QUANTUM = 1'b0,
        CFG_LOCK    = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCH_RD,
        S_SCH_ID,
        S_SCH_EV,
        S_SCH_MUL,
        S_SLOT_EV,
        S_SRCH_RD,
        S_SRCH_EV,
        S_RET_EV,
        S_SH_RD,
        S_SH_WR
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   raddr;
        logic [ID_W-1:0]   waddr;
        logic              st_we;
        t_status           st_wdata;
        logic              pr_we;
        logic [PRIO_W-1:0] pr_wdata;
        logic              wk_we;
        logic [TIME_W-1:0] wk_wdata;
    } t_slot_req;

endpackage

// File: hw/rtl/round_robin_thread_scheduler.sv
// Round-robin thread scheduler: top level with config registers and memories.
// An item is taken when i_start is high and o_busy low; its one result shows
// for exactly one cycle with o_done and cannot be held off, so capture it then.
// Steps: unknown actions, and schedule or retire on an empty ring, answer
// from idle; add and set wait read the thread's slot, then write it; a
// schedule reads each ring entry and then its slot, moving entries that are
// not runnable to the tail, until one is runnable, then multiplies the slice;
// remove reads the slot, searches the ring and shifts later entries down;
// retire frees the head and shifts the rest down. The ring memory has a single
// registered read port. o_busy drops in the cycle the result is shown, so
// the next request can follow at once. Configuration writes are always ready.
`timescale 1ns / 1ps
module round_robin_thread_scheduler import rrts_pkg::*; #(
    parameter int MAX_THREADS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [2:0]           i_action,
    input  logic [ID_W-1:0]      i_thread_id,
    input  logic [PRIO_W-1:0]    i_priority_req,
    input  logic                 i_wait_kind,
    input  logic [TIME_W-1:0]    i_wake_time,
    input  logic [TIME_W-1:0]    i_now,
    input  logic [ID_SLOTS-1:0]  i_blocked_mask,
    output logic                 o_done,
    output logic                 o_accepted,
    output logic                 o_found,
    output logic [ID_W-1:0]      o_selected_thread,
    output logic                 o_timer_run,
    output logic [PERIOD_W-1:0]  o_timer_period,
    output logic                 o_list_empty,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int PW = $clog2(MAX_THREADS);

    logic [QUANT_W-1:0] r_quantum;
    logic [PRIO_W-1:0]  r_lock;

    logic               ring_we;
    logic [PW-1:0]      ring_waddr;
    logic [ID_W-1:0]    ring_wdata;
    logic [PW-1:0]      ring_raddr;
    logic [ID_W-1:0]    ring_rdata;
    t_slot_req          slot_req;
    logic [2:0]         st_rdata;
    logic [PRIO_W-1:0]  pr_rdata;
    logic [TIME_W-1:0]  wk_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANT_W'(1000);
            r_lock    <= PRIO_W'(255);
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_QUANTUM: r_quantum <= i_cfg_data;
                CFG_LOCK:    r_lock    <= i_cfg_data[PRIO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rrts_ram #(.DEPTH(MAX_THREADS), .WIDTH(ID_W)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    rrts_ram #(.DEPTH(ID_SLOTS), .WIDTH(3)) u_status (
        .i_clk   (i_clk),
        .i_we    (slot_req.st_we),
        .i_waddr (slot_req.waddr),
        .i_wdata (slot_req.st_wdata),
        .i_raddr (slot_req.raddr),
        .o_rdata (st_rdata)
    );

    rrts_ram #(.DEPTH(ID_SLOTS), .WIDTH(PRIO_W)) u_prio (
        .i_clk   (i_clk),
        .i_we    (slot_req.pr_we),
        .i_waddr (slot_req.waddr),
        .i_wdata (slot_req.pr_wdata),
        .i_raddr (slot_req.raddr),
        .o_rdata (pr_rdata)
    );

    rrts_ram #(.DEPTH(ID_SLOTS), .WIDTH(TIME_W)) u_wake (
        .i_clk   (i_clk),
        .i_we    (slot_req.wk_we),
        .i_waddr (slot_req.waddr),
        .i_wdata (slot_req.wk_wdata),
        .i_raddr (slot_req.raddr),
        .o_rdata (wk_rdata)
    );

    rrts_ctrl #(.MAX_THREADS(MAX_THREADS)) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_action          (i_action),
        .i_thread_id       (i_thread_id),
        .i_priority_req    (i_priority_req),
        .i_wait_kind       (i_wait_kind),
        .i_wake_time       (i_wake_time),
        .i_now             (i_now),
        .i_blocked_mask    (i_blocked_mask),
        .i_quantum         (r_quantum),
        .i_lock_priority   (r_lock),
        .o_ring_we         (ring_we),
        .o_ring_waddr      (ring_waddr),
        .o_ring_wdata      (ring_wdata),
        .o_ring_raddr      (ring_raddr),
        .i_ring_rdata      (ring_rdata),
        .o_slot_req        (slot_req),
        .i_st_rdata        (st_rdata),
        .i_pr_rdata        (pr_rdata),
        .i_wk_rdata        (wk_rdata),
        .o_done            (o_done),
        .o_accepted        (o_accepted),
        .o_found           (o_found),
        .o_selected_thread (o_selected_thread),
        .o_timer_run       (o_timer_run),
        .o_timer_period    (o_timer_period),
        .o_list_empty      (o_list_empty)
    );

endmodule

// File: hw/rtl/rrts_ram.sv
// Simple dual-port memory with registered read.
`timescale 1ns / 1ps
module rrts_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/rrts_ctrl.sv
// Sequencer for the scheduler: walks the ring and updates slot memories.
`timescale 1ns / 1ps
module rrts_ctrl import rrts_pkg::*; #(
    parameter int MAX_THREADS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [2:0]                       i_action,
    input  logic [ID_W-1:0]                  i_thread_id,
    input  logic [PRIO_W-1:0]                i_priority_req,
    input  logic                             i_wait_kind,
    input  logic [TIME_W-1:0]                i_wake_time,
    input  logic [TIME_W-1:0]                i_now,
    input  logic [ID_SLOTS-1:0]              i_blocked_mask,
    input  logic [QUANT_W-1:0]               i_quantum,
    input  logic [PRIO_W-1:0]                i_lock_priority,
    output logic                             o_ring_we,
    output logic [$clog2(MAX_THREADS)-1:0]   o_ring_waddr,
    output logic [ID_W-1:0]                  o_ring_wdata,
    output logic [$clog2(MAX_THREADS)-1:0]   o_ring_raddr,
    input  logic [ID_W-1:0]                  i_ring_rdata,
    output t_slot_req                        o_slot_req,
    input  logic [2:0]                       i_st_rdata,
    input  logic [PRIO_W-1:0]                i_pr_rdata,
    input  logic [TIME_W-1:0]                i_wk_rdata,
    output logic                             o_done,
    output logic                             o_accepted,
    output logic                             o_found,
    output logic [ID_W-1:0]                  o_selected_thread,
    output logic                             o_timer_run,
    output logic [PERIOD_W-1:0]              o_timer_period,
    output logic                             o_list_empty
);

    localparam int PW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        logic [PW-1:0] res;
        res = (p == PW'(MAX_THREADS - 1)) ? '0 : PW'(p + 1'b1);
        return res;
    endfunction

    t_state r_state, n_state;

    logic [PW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic [CW:0]           r_visit, n_visit;
    logic [PW-1:0]         r_p, n_p;
    logic [CW-1:0]         r_i, n_i;
    logic [ID_W-1:0]       r_id, n_id;
    logic [PRIO_W-1:0]     r_prio, n_prio;
    logic [ID_SLOTS-1:0]   r_st_valid;

    logic [2:0]            r_action;
    logic [ID_W-1:0]       r_tid;
    logic [PRIO_W-1:0]     r_prio_req;
    logic                  r_kind;
    logic [TIME_W-1:0]     r_wake;
    logic [TIME_W-1:0]     r_now;
    logic [ID_SLOTS-1:0]   r_bmask;

    logic                  r_done, n_done;
    logic                  r_acc, n_acc;
    logic                  r_found, n_found;
    logic [ID_W-1:0]       r_sel, n_sel;
    logic                  r_trun, n_trun;
    logic [PERIOD_W-1:0]   r_period, n_period;
    logic                  r_empty;

    logic                  w_accept;
    t_status               w_status;
    logic [PW:0]           w_sum;
    logic [PW-1:0]         w_tail;
    logic                  w_visit_last;
    logic                  w_srch_last;
    logic                  w_sh_more;
    logic                  w_can_add;
    logic [PERIOD_W-1:0]   w_product;

    assign w_accept     = i_start && (r_state == S_IDLE);
    assign w_status     = r_st_valid[r_id] ? t_status'(i_st_rdata) : ST_ABSENT;
    assign w_sum        = {1'b0, r_head} + (PW+1)'(r_count);
    assign w_tail       = (w_sum >= (PW+1)'(MAX_THREADS)) ?
                          PW'(w_sum - (PW+1)'(MAX_THREADS)) : PW'(w_sum);
    assign w_visit_last = ((CW+1)'(r_visit + 1'b1)) == {r_count, 1'b0};
    assign w_srch_last  = (CW'(r_i + 1'b1)) == r_count;
    assign w_sh_more    = (CW'(r_i + 1'b1)) < r_count;
    assign w_can_add    = (w_status == ST_ABSENT) && (r_count != CW'(MAX_THREADS));
    assign w_product    = {8'd0, i_quantum} * {16'd0, r_prio};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (t_action'(i_action))
                        ACT_SCHEDULE: n_state = (r_count == '0) ? S_IDLE : S_SCH_RD;
                        ACT_ADD, ACT_REMOVE, ACT_WAIT: n_state = S_SLOT_EV;
                        ACT_RETIRE: n_state = (r_count == '0) ? S_IDLE : S_RET_EV;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCH_RD: n_state = S_SCH_ID;
            S_SCH_ID: n_state = S_SCH_EV;
            S_SCH_EV: begin
                if (w_status == ST_RUNNABLE) begin
                    n_state = S_SCH_MUL;
                end else begin
                    n_state = w_visit_last ? S_IDLE : S_SCH_RD;
                end
            end
            S_SCH_MUL: n_state = S_IDLE;
            S_SLOT_EV: begin
                if (t_action'(r_action) == ACT_REMOVE && w_status != ST_ABSENT) begin
                    n_state = S_SRCH_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SRCH_RD: n_state = S_SRCH_EV;
            S_SRCH_EV: begin
                if (i_ring_rdata == r_tid) begin
                    n_state = S_SH_RD;
                end else begin
                    n_state = w_srch_last ? S_IDLE : S_SRCH_RD;
                end
            end
            S_RET_EV: n_state = S_SH_RD;
            S_SH_RD:  n_state = w_sh_more ? S_SH_WR : S_IDLE;
            S_SH_WR:  n_state = S_SH_RD;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_visit      = r_visit;
        n_p          = r_p;
        n_i          = r_i;
        n_id         = r_id;
        n_prio       = r_prio;
        n_done       = 1'b0;
        n_acc        = 1'b0;
        n_found      = 1'b0;
        n_sel        = '0;
        n_trun       = 1'b0;
        n_period     = '0;
        o_ring_we    = 1'b0;
        o_ring_waddr = r_head;
        o_ring_wdata = r_id;
        o_ring_raddr = r_head;
        o_slot_req   = '{raddr: r_id, waddr: r_id, st_we: 1'b0, st_wdata: ST_ABSENT,
                         pr_we: 1'b0, pr_wdata: r_prio_req, wk_we: 1'b0,
                         wk_wdata: r_wake};
        case (r_state)
            S_IDLE: begin
                o_slot_req.raddr = i_thread_id;
                n_id             = i_thread_id;
                n_visit          = '0;
                if (i_start) begin
                    case (t_action'(i_action))
                        ACT_SCHEDULE: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                                n_acc  = 1'b1;
                            end
                        end
                        ACT_ADD, ACT_REMOVE, ACT_WAIT: begin
                        end
                        ACT_RETIRE: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                            end
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            S_SCH_RD: o_ring_raddr = r_head;
            S_SCH_ID: begin
                o_slot_req.raddr = i_ring_rdata;
                n_id             = i_ring_rdata;
            end
            S_SCH_EV: begin
                if (w_status == ST_RUNNABLE) begin
                    o_slot_req.st_we    = 1'b1;
                    o_slot_req.st_wdata = ST_RUNNING;
                    n_prio              = i_pr_rdata;
                end else begin
                    case (w_status)
                        ST_BLOCKED: begin
                            if (!r_bmask[r_id]) begin
                                o_slot_req.st_we    = 1'b1;
                                o_slot_req.st_wdata = ST_RUNNABLE;
                            end
                        end
                        ST_SLEEPING: begin
                            if (r_now >= i_wk_rdata) begin
                                o_slot_req.st_we    = 1'b1;
                                o_slot_req.st_wdata = ST_RUNNABLE;
                                o_slot_req.wk_we    = 1'b1;
                                o_slot_req.wk_wdata = '0;
                            end
                        end
                        ST_RUNNING: begin
                            o_slot_req.st_we    = 1'b1;
                            o_slot_req.st_wdata = ST_RUNNABLE;
                        end
                        default: begin
                        end
                    endcase
                    o_ring_we    = 1'b1;
                    o_ring_waddr = w_tail;
                    o_ring_wdata = r_id;
                    n_head       = f_inc(r_head);
                    n_visit      = (CW+1)'(r_visit + 1'b1);
                    if (w_visit_last) begin
                        n_done = 1'b1;
                        n_acc  = 1'b1;
                    end
                end
            end
            S_SCH_MUL: begin
                n_done   = 1'b1;
                n_acc    = 1'b1;
                n_found  = 1'b1;
                n_sel    = r_id;
                n_trun   = (r_prio != i_lock_priority);
                n_period = w_product;
            end
            S_SLOT_EV: begin
                case (t_action'(r_action))
                    ACT_ADD: begin
                        n_done = 1'b1;
                        if (w_can_add) begin
                            o_ring_we           = 1'b1;
                            o_ring_waddr        = w_tail;
                            o_ring_wdata        = r_tid;
                            n_count             = CW'(r_count + 1'b1);
                            o_slot_req.st_we    = 1'b1;
                            o_slot_req.st_wdata = ST_RUNNABLE;
                            o_slot_req.pr_we    = 1'b1;
                            n_acc               = 1'b1;
                        end
                    end
                    ACT_WAIT: begin
                        n_done = 1'b1;
                        if (w_status != ST_ABSENT) begin
                            o_slot_req.st_we = 1'b1;
                            if (r_kind) begin
                                o_slot_req.st_wdata = ST_SLEEPING;
                                o_slot_req.wk_we    = 1'b1;
                            end else begin
                                o_slot_req.st_wdata = ST_BLOCKED;
                            end
                            n_acc = 1'b1;
                        end
                    end
                    default: begin
                        n_p = r_head;
                        n_i = '0;
                        if (w_status == ST_ABSENT) begin
                            n_done = 1'b1;
                        end
                    end
                endcase
            end
            S_SRCH_RD: o_ring_raddr = r_p;
            S_SRCH_EV: begin
                if (i_ring_rdata == r_tid) begin
                    o_slot_req.waddr    = r_tid;
                    o_slot_req.st_we    = 1'b1;
                    o_slot_req.st_wdata = ST_ABSENT;
                end else begin
                    n_p = f_inc(r_p);
                    n_i = CW'(r_i + 1'b1);
                    if (w_srch_last) begin
                        n_done = 1'b1;
                    end
                end
            end
            S_RET_EV: begin
                o_slot_req.waddr    = i_ring_rdata;
                o_slot_req.st_we    = 1'b1;
                o_slot_req.st_wdata = ST_ABSENT;
                n_p                 = r_head;
                n_i                 = '0;
            end
            S_SH_RD: begin
                o_ring_raddr = f_inc(r_p);
                if (!w_sh_more) begin
                    n_count = CW'(r_count - 1'b1);
                    n_done  = 1'b1;
                    n_acc   = 1'b1;
                end
            end
            S_SH_WR: begin
                o_ring_we    = 1'b1;
                o_ring_waddr = r_p;
                o_ring_wdata = i_ring_rdata;
                n_p          = f_inc(r_p);
                n_i          = CW'(r_i + 1'b1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_count    <= '0;
            r_st_valid <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_done  <= n_done;
            if (o_slot_req.st_we) begin
                r_st_valid[o_slot_req.waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_visit <= n_visit;
        r_p     <= n_p;
        r_i     <= n_i;
        r_id    <= n_id;
        r_prio  <= n_prio;
        if (w_accept) begin
            r_action   <= i_action;
            r_tid      <= i_thread_id;
            r_prio_req <= i_priority_req;
            r_kind     <= i_wait_kind;
            r_wake     <= i_wake_time;
            r_now      <= i_now;
            r_bmask    <= i_blocked_mask;
        end
        if (n_done) begin
            r_acc    <= n_acc;
            r_found  <= n_found;
            r_sel    <= n_sel;
            r_trun   <= n_trun;
            r_period <= n_period;
            r_empty  <= (n_count == '0);
        end
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_accepted        = r_acc;
    assign o_found           = r_found;
    assign o_selected_thread = r_sel;
    assign o_timer_run       = r_trun;
    assign o_timer_period    = r_period;
    assign o_list_empty      = r_empty;

endmodule

// File: hw/rtl/rrts_checker.sv
// Port-level checks for the round-robin thread scheduler, bound to the top.
`timescale 1ns / 1ps
`include "round_robin_thread_scheduler_macros.svh"
module rrts_checker import rrts_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                o_busy,
    input logic                o_done,
    input logic                o_accepted,
    input logic                o_found,
    input logic [ID_W-1:0]     o_selected_thread,
    input logic                o_timer_run,
    input logic [PERIOD_W-1:0] o_timer_period,
    input logic                o_list_empty
);

    `RRTS_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy || o_done)
    `RRTS_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !o_busy)
    `RRTS_ASSERT_NOW(a_found_acc, i_clk, i_rst_n, o_done && o_found, o_accepted && !o_list_empty)
    `RRTS_ASSERT_NOW(a_none_zero, i_clk, i_rst_n, o_done && !o_found, o_selected_thread == '0 && !o_timer_run && o_timer_period == '0)

endmodule

bind round_robin_thread_scheduler rrts_checker u_rrts_checker (.*);
